/* hdl/gf2ppt_pkg.sv */
package gf2ppt_pkg;

    // fixed field widths
    localparam int POLY_W = 24;
    localparam int LEN_W  = 5;

    // poly_length after reset
    localparam logic [LEN_W-1:0] LEN_RESET = 5'd24;

    // smallest odd trial divisor
    localparam int FIRST_DIVISOR = 3;

    // command from the sequencer to an iterative unit
    typedef struct packed {
        logic load;   // restart the unit
        logic step;   // advance one iteration
    } t_unit_cmd;

    // status back from an iterative unit
    typedef struct packed {
        logic done;   // no iterations left
        logic hit;    // exact division / state came back to 1
    } t_unit_sts;

endpackage

/* hdl/gf2ppt_div.sv */
// Trial divisor test, one elimination step per cycle while step is set (LSB first).
module gf2ppt_div
    import gf2ppt_pkg::*;
#(
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  t_unit_cmd     i_cmd,
    input  logic [DW-1:0] i_poly,
    input  logic [DW-1:0] i_divisor,
    input  logic [DW:0]   i_len_lim,
    output t_unit_sts     o_sts
);

    logic [DW-1:0] r_val;
    logic [DW:0]   r_lim;
    logic [DW-1:0] n_val;
    logic          w_more;

    // keep going while the divisor still fits under the shrinking limit
    assign w_more = ({1'b0, i_divisor} < r_lim);
    assign n_val  = (r_val ^ (r_val[0] ? i_divisor : '0)) >> 1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= i_poly;
            r_lim <= i_len_lim;
        end else if (i_cmd.step && w_more) begin
            r_val <= n_val;
            r_lim <= r_lim >> 1;
        end
    end

    assign o_sts.done = !w_more;
    assign o_sts.hit  = (r_val == '0);

endmodule

/* hdl/gf2ppt_lfsr.sv */
// Fibonacci LFSR period walk, one shift per cycle while step is set.
module gf2ppt_lfsr
    import gf2ppt_pkg::*;
#(
    parameter int DW = 24
) (
    input  logic             i_clk,
    input  t_unit_cmd        i_cmd,
    input  logic [DW-1:0]    i_taps,
    input  logic [LEN_W-1:0] i_deg,
    output t_unit_sts        o_sts
);

    logic [DW-2:0] r_s;
    logic [DW-2:0] r_k;
    logic          r_hit;

    logic [DW-1:0] w_pow;
    logic [DW-2:0] w_steps;
    logic [DW-2:0] w_smask;
    logic [DW-1:0] w_t;
    logic          w_fb;
    logic [DW-2:0] n_s;

    assign w_pow   = DW'(1) << i_deg;
    assign w_steps = (DW-1)'(w_pow - DW'(2));
    assign w_smask = (DW-1)'(w_pow - DW'(1));

    assign w_t  = {r_s, 1'b0};
    assign w_fb = ^(w_t & i_taps);
    assign n_s  = (w_t[DW-2:0] | (DW-1)'(w_fb)) & w_smask;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s   <= (DW-1)'(1);
            r_k   <= w_steps;
            r_hit <= 1'b0;
        end else if (i_cmd.step && (r_k != '0)) begin
            r_s   <= n_s;
            r_k   <= r_k - (DW-1)'(1);
            r_hit <= (n_s == (DW-1)'(1));
        end
    end

    assign o_sts.done = (r_k == '0);
    assign o_sts.hit  = r_hit;

endmodule

/* hdl/gf2_primitive_polynomial_test_unit.sv */
// GF(2) primitive polynomial tester. Each transfer on the input channel
// carries one candidate polynomial (bit k = coefficient of x^k); bits at
// poly_length and above are ignored, and the degree is poly_length - 1.
// One result transfer follows per input: irreducible is set when the
// constant term is 1, the top coefficient is 1, and no odd trial divisor
// d, 3 <= d < 2^ceil(poly_length/2), divides the polynomial exactly;
// primitive_res is set when it is irreducible and a Fibonacci LFSR started
// at state 1 (taps = coefficients 1..deg) does not come back to 1 within
// 2^deg - 2 shifts. A poly_length outside 2..DW (DW is the smaller of
// MAX_LENGTH and POLY_W), a clear top bit or a clear constant term gives 0
// on both flags. Items are handled one at a time: o_ready is high only
// between items. After the input transfer the item goes through a check,
// the trial division unit, one divisor after another, then the LFSR walk,
// one shift per cycle, and a push into the output register. At
// poly_length 24 almost all of the time for a primitive polynomial goes
// to the LFSR walk. The finished result sits in an output register, so the
// next item may be taken while it waits. The user must write poly_length
// through i_cfg_we / i_cfg_data between items only; the block itself does
// not enforce this. It resets to 24.
module gf2_primitive_polynomial_test_unit
    import gf2ppt_pkg::*;
#(
    parameter int MAX_LENGTH = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_data,
    // input channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [POLY_W-1:0] i_polynomial,
    // result channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_irreducible,
    output logic              o_primitive_res
);

    // datapath width: no result can be nonzero beyond the input field width
    localparam int DW = (MAX_LENGTH < POLY_W) ? MAX_LENGTH : POLY_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_LFSR  = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [LEN_W-1:0] r_cfg_len;
    logic [LEN_W-1:0] r_len, n_len;
    logic [DW-1:0]    r_raw, n_raw;
    logic [DW-1:0]    r_div, n_div;
    logic             r_irr, n_irr;
    logic             r_prim, n_prim;
    logic             r_out_valid, n_out_valid;
    logic             r_out_irr, n_out_irr;
    logic             r_out_prim, n_out_prim;

    // derived values; all but w_div_next and w_div_more are stable while the item is worked on
    logic [DW:0]      w_len_lim;
    logic [DW-1:0]    w_lmask;
    logic [DW-1:0]    w_p;
    logic             w_len_ok;
    logic             w_topbit;
    logic [LEN_W-1:0] w_half;
    logic [DW:0]      w_top;
    logic [DW:0]      w_div_next;
    logic             w_div_more;
    logic             w_first_more;
    logic [LEN_W-1:0] w_deg;
    logic [DW-1:0]    w_taps;

    t_unit_cmd        div_cmd, lfsr_cmd;
    t_unit_sts        div_sts, lfsr_sts;

    assign w_len_ok     = (r_len >= LEN_W'(2)) && (r_len <= LEN_W'(DW));
    assign w_len_lim    = (DW+1)'(1) << r_len;
    assign w_lmask      = DW'(w_len_lim - (DW+1)'(1));
    assign w_p          = r_raw & w_lmask;
    assign w_topbit     = |(w_p & DW'(w_len_lim >> 1));
    // trial divisors run below 2^ceil(len/2)
    assign w_half       = LEN_W'(((LEN_W+1)'(r_len) + (LEN_W+1)'(1)) >> 1);
    assign w_top        = (DW+1)'(1) << w_half;
    assign w_div_next   = (DW+1)'(r_div) + (DW+1)'(2);
    assign w_div_more   = (w_div_next < w_top);
    assign w_first_more = ((DW+1)'(FIRST_DIVISOR) < w_top);
    assign w_deg        = r_len - LEN_W'(1);
    assign w_taps       = w_p & ~DW'(1);

    gf2ppt_div #(.DW(DW)) u_div (
        .i_clk     (i_clk),
        .i_cmd     (div_cmd),
        .i_poly    (w_p),
        .i_divisor (r_div),
        .i_len_lim (w_len_lim),
        .o_sts     (div_sts)
    );

    gf2ppt_lfsr #(.DW(DW)) u_lfsr (
        .i_clk  (i_clk),
        .i_cmd  (lfsr_cmd),
        .i_taps (w_taps),
        .i_deg  (w_deg),
        .o_sts  (lfsr_sts)
    );

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_raw       = r_raw;
        n_div       = r_div;
        n_irr       = r_irr;
        n_prim      = r_prim;
        n_out_valid = r_out_valid & ~i_ready;
        n_out_irr   = r_out_irr;
        n_out_prim  = r_out_prim;
        div_cmd     = '0;
        lfsr_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_raw   = DW'(i_polynomial);
                    n_len   = r_cfg_len;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_irr  = 1'b0;
                n_prim = 1'b0;
                n_div  = DW'(FIRST_DIVISOR);
                if (!w_len_ok || !w_topbit || !w_p[0]) begin
                    n_state = S_PUSH;
                end else if (w_first_more) begin
                    div_cmd.load = 1'b1;
                    n_state      = S_DIV;
                end else begin
                    // no divisors to try (degree one)
                    n_irr         = 1'b1;
                    lfsr_cmd.load = 1'b1;
                    n_state       = S_LFSR;
                end
            end
            S_DIV: begin
                if (!div_sts.done) begin
                    div_cmd.step = 1'b1;
                end else if (div_sts.hit) begin
                    // exact factor found
                    n_state = S_PUSH;
                end else begin
                    n_div = DW'(w_div_next);
                    if (w_div_more) begin
                        div_cmd.load = 1'b1;
                    end else begin
                        n_irr         = 1'b1;
                        lfsr_cmd.load = 1'b1;
                        n_state       = S_LFSR;
                    end
                end
            end
            S_LFSR: begin
                if (lfsr_sts.hit) begin
                    // short period
                    n_state = S_PUSH;
                end else if (lfsr_sts.done) begin
                    n_prim  = 1'b1;
                    n_state = S_PUSH;
                end else begin
                    lfsr_cmd.step = 1'b1;
                end
            end
            S_PUSH: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_irr   = r_irr;
                    n_out_prim  = r_prim;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cfg_len   <= LEN_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_raw      <= n_raw;
        r_div      <= n_div;
        r_irr      <= n_irr;
        r_prim     <= n_prim;
        r_out_irr  <= n_out_irr;
        r_out_prim <= n_out_prim;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_irreducible   = r_out_irr;
    assign o_primitive_res = r_out_prim;

`ifndef NO_ASSERTIONS
    a_prim_needs_irr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_primitive_res || o_irreducible))
        else $error("primitive flagged without irreducible");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second item taken while one is in work");

    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_div[0])
        else $error("even trial divisor");

    a_result_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> ($past(r_state) == S_PUSH))
        else $error("result appeared outside the push state");
`endif

endmodule
